// File: sv/srtt_pkg.sv
// ----------------------------------------------------------------------------
// srtt_pkg: shared types and constants for the radix-to-text converter
// opcodes, character codes and the divider status record
// ----------------------------------------------------------------------------
package srtt_pkg;

  localparam int WORD_W = 32;
  localparam int CHAR_W = 8;
  localparam int CODE_W = 7;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_CONVERT = 2'd2;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

  typedef struct packed {
    logic busy;
    logic done;
  } srtt_div_stat_t;

endpackage

// File: sv/signed_radix_to_text.sv
// ----------------------------------------------------------------------------
// signed_radix_to_text: signed 32-bit number to text in a loaded alphabet
// clear and append items build the alphabet, convert items emit characters
// ----------------------------------------------------------------------------
// clear, append and an invalid convert are handled on accept and leave busy low
// convert: D digits (1 to 32), each the remainder of a pass through the shared
//   divider, are buffered and then emitted most significant first
// one item at a time: busy stays high until the newline has been emitted
// the receiver cannot stall: each character is shown for one cycle only
// synchronous active-low reset empties the alphabet; the stores are not cleared
module signed_radix_to_text #(
  parameter int MAX_SYMBOLS = 128,
  parameter int MAX_DIGITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_opcode,
  input  logic [srtt_pkg::CHAR_W-1:0] in_symbol,
  input  logic signed [31:0]          in_number,
  output logic                        out_valid,
  output logic [srtt_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last
);
  import srtt_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);   // symbol count and base
  localparam int SYM_AW = $clog2(MAX_SYMBOLS);       // alphabet address
  localparam int DIG_AW = $clog2(MAX_DIGITS);        // digit buffer address
  localparam int NDIG_W = $clog2(MAX_DIGITS + 1);    // digit count

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIV    = 2'd1;
  localparam logic [1:0] S_RD_DIG = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  // state and alphabet bookkeeping
  logic [1:0]        state_r;
  logic              rd_sym_r;    // second read stage of a digit
  logic [127:0]      presence_r;
  logic [CNT_W-1:0]  count_r;
  logic              bad_r;
  logic [NDIG_W-1:0] ndig_r;

  // stores
  logic [CODE_W-1:0] sym_mem [MAX_SYMBOLS];
  logic [SYM_AW-1:0] dig_mem [MAX_DIGITS];
  logic [SYM_AW-1:0] dig_rd_r;
  logic [CODE_W-1:0] sym_rd_r;

  // output register
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  // divider hookup
  srtt_div_stat_t    div_stat;
  logic              div_start;
  logic [WORD_W-1:0] div_dividend;
  logic [WORD_W-1:0] div_quot;
  logic [CNT_W-1:0]  div_rem;

  logic              accept;
  logic              alpha_ok;
  logic              forbidden;
  logic [CODE_W-1:0] code;
  logic [WORD_W-1:0] num_u;
  logic [WORD_W-1:0] mag;
  logic [NDIG_W-1:0] ndig_dec;
  logic              dig_wr;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign alpha_ok = !bad_r && (count_r >= CNT_W'(2));
  assign code     = in_symbol[CODE_W-1:0];
  assign forbidden = (in_symbol == CH_PLUS) || (in_symbol == CH_MINUS) ||
                     (in_symbol < CH_SPACE) || (in_symbol > CH_TILDE);

  // magnitude through unsigned negation covers the most negative value
  assign num_u = in_number;
  assign mag   = num_u[WORD_W-1] ? (WORD_W'(0) - num_u) : num_u;

  // first division from the accepted number, later ones from the quotient
  assign div_start    = (accept && (in_opcode == OP_CONVERT) && alpha_ok) ||
                        ((state_r == S_DIV) && div_stat.done && (div_quot != '0));
  assign div_dividend = (state_r == S_IDLE) ? mag : div_quot;

  assign dig_wr   = (state_r == S_DIV) && div_stat.done &&
                    (ndig_r < NDIG_W'(MAX_DIGITS));
  assign ndig_dec = ndig_r - 1'b1;

  srtt_divider #(
    .DIV_W (CNT_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (count_r),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // alphabet bookkeeping and the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_sym_r    <= 1'b0;
      presence_r  <= '0;
      count_r     <= '0;
      bad_r       <= 1'b0;
      ndig_r      <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_opcode)
              OP_CLEAR: begin
                presence_r <= '0;
                count_r    <= '0;
                bad_r      <= 1'b0;
              end
              OP_APPEND: begin
                if (count_r == CNT_W'(MAX_SYMBOLS)) begin
                  bad_r <= 1'b1;     // alphabet full, symbol dropped
                end else begin
                  count_r <= count_r + 1'b1;
                  if (forbidden) begin
                    bad_r <= 1'b1;
                  end else begin
                    if (presence_r[code]) begin
                      bad_r <= 1'b1;  // repeated symbol
                    end
                    presence_r[code] <= 1'b1;
                  end
                end
              end
              OP_CONVERT: begin
                if (alpha_ok) begin
                  state_r <= S_DIV;
                  ndig_r  <= '0;
                  if (num_u[WORD_W-1]) begin
                    out_valid_r <= 1'b1;  // leading minus sign
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (dig_wr) begin
              ndig_r <= ndig_r + 1'b1;
            end
            if (div_quot == '0) begin
              state_r <= S_RD_DIG;
            end
          end
        end
        S_RD_DIG: begin
          // digits go out most significant first
          if (ndig_r == '0) begin
            out_valid_r <= 1'b1;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            ndig_r   <= ndig_dec;
            rd_sym_r <= 1'b1;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          // first pass waits for the alphabet read, the second registers the character
          if (rd_sym_r) begin
            rd_sym_r <= 1'b0;
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= S_RD_DIG;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // output character payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      out_char_r <= CH_MINUS;
    end else if (state_r == S_RD_DIG) begin
      out_char_r <= CH_NL;
    end else begin
      out_char_r <= {1'b0, sym_rd_r};
    end
  end

  // alphabet store: written on append, read at the digit value
  always_ff @(posedge clk) begin
    if (accept && (in_opcode == OP_APPEND) && (count_r != CNT_W'(MAX_SYMBOLS))) begin
      sym_mem[count_r[SYM_AW-1:0]] <= code;
    end
    sym_rd_r <= sym_mem[dig_rd_r];
  end

  // digit buffer: remainders, least significant first
  always_ff @(posedge clk) begin
    if (dig_wr) begin
      dig_mem[ndig_r[DIG_AW-1:0]] <= div_rem[SYM_AW-1:0];
    end
    dig_rd_r <= dig_mem[ndig_dec[DIG_AW-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // a character only follows a conversion in progress or its accept
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) != S_IDLE) || $past(start && !busy))
    else $error("character emitted outside a conversion");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("last marker without a character");

  a_bad_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == OP_CONVERT) && !alpha_ok) |=> !out_valid && !busy)
    else $error("invalid alphabet produced output");

  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |-> (state_r == S_DIV))
    else $error("divider active outside the division phase");

  a_ndig_range: assert property (@(posedge clk) disable iff (!rst_n)
    ndig_r <= NDIG_W'(MAX_DIGITS))
    else $error("digit count beyond buffer depth");

endmodule

// File: sv/srtt_divider.sv
// ----------------------------------------------------------------------------
// srtt_divider: shared iterative divider
// restoring division of a 32-bit word by a narrow divisor, one bit a cycle
// ----------------------------------------------------------------------------
module srtt_divider #(
  parameter int DIV_W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [srtt_pkg::WORD_W-1:0] dividend,
  input  logic [DIV_W-1:0]            divisor,
  output srtt_pkg::srtt_div_stat_t    stat,
  output logic [srtt_pkg::WORD_W-1:0] quotient,
  output logic [DIV_W-1:0]            remainder
);
  import srtt_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic [WORD_W-1:0] quot_r;
  logic [DIV_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;
  logic              ge;

  assign shifted = {rem_r, quot_r[WORD_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign ge      = (shifted >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
    end else if (busy_r) begin
      quot_r <= {quot_r[WORD_W-2:0], ge};
      rem_r  <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quot_r;
  assign remainder = rem_r;

endmodule
